FILE: design/trs_pkg.sv
// Shared types, constants and rounding helpers for the TRS matrix block.
`timescale 1ns / 1ps
package trs_pkg;

	localparam int SC_STAGES  = 12;
	localparam int ROT_STAGES = 5;
	localparam int SCL_STAGES = 3;
	localparam int TOT_STAGES = SC_STAGES + ROT_STAGES + SCL_STAGES;

	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [26:0] PI_OVER_180 = 27'd74961321;

	// ceil(2^(31+l)/d) with l = ceil(log2 d): exact quotient for inputs below 2^31
	localparam logic [31:0] M42 = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
	localparam logic [31:0] M56 = 32'(((64'd1 << 37) + 64'd55) / 64'd56);
	localparam logic [31:0] M20 = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
	localparam logic [31:0] M30 = 32'(((64'd1 << 36) + 64'd29) / 64'd30);
	localparam logic [31:0] M6  = 32'(((64'd1 << 34) + 64'd5) / 64'd6);
	localparam logic [31:0] M12 = 32'(((64'd1 << 35) + 64'd11) / 64'd12);

	localparam logic signed [35:0] SAT_HI = 36'sh07FFFFFFF;
	localparam logic signed [35:0] SAT_LO = 36'shF80000000;

	typedef logic signed [32:0] rent_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} vec3_t;

	// drop 30 fraction bits, rounding half away from zero
	function automatic logic signed [35:0] rnd_q30(input logic signed [64:0] p);
		logic [64:0] mag;
		logic [64:0] sum;
		logic signed [35:0] r;
		mag = p[64] ? 65'(-p) : 65'(p);
		sum = mag + 65'(1 << 29);
		r = $signed({1'b0, sum[64:30]});
		return p[64] ? -r : r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [35:0] v);
		logic [31:0] r;
		if (v > SAT_HI) begin
			r = 32'h7FFF_FFFF;
		end else if (v < SAT_LO) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

FILE: design/trs_sincos.sv
// Pipelined sine and cosine of an angle in degrees, Q30 results.
`timescale 1ns / 1ps
module trs_sincos import trs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        angle,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	localparam int WH    = 32 - FRAC_BITS;
	localparam int HUW   = ((WH > 9) ? WH : 9) + 1;
	localparam int SH360 = HUW + 9;
	localparam int PW    = 2 * HUW + 1;
	localparam int MW    = FRAC_BITS + 6;
	localparam logic [63:0] OFS = 64'd360 * (((64'd1 << (WH - 1)) + 64'd359) / 64'd360);
	localparam logic [HUW:0] R360 = (HUW + 1)'(((64'd1 << SH360) + 64'd359) / 64'd360);
	localparam logic [MW-1:0] OCT = MW'(45) << FRAC_BITS;

	logic [PW-1:0]        prod_s1;
	logic [HUW-1:0]       hu_s1;
	logic [FRAC_BITS-1:0] low_s1, low_s2;
	logic [8:0]           v_s2;
	logic [2:0]           k_s3, k_s4, k_s5, k_s6, k_s7, k_s8, k_s9, k_s10, k_s11;
	logic [MW-1:0]        m_s3;
	logic [MW+26:0]       pm_s4;
	logic [29:0]          x_s5, x_s6, x_s7, x_s8, x_s9, x_s10;
	logic [59:0]          px2_s5;
	logic [29:0]          x2_s6, x2_s7, x2_s8, x2_s9, x2_s10;
	logic [61:0]          p42_s6, p56_s6;
	logic [60:0]          ms_s7, mc_s7, ms_s9, mc_s9, ms_s11, mc_s11;
	logic [62:0]          p20_s8, p30_s8, p6_s10, p12_s10;
	logic signed [31:0]   s_s12, c_s12;

	logic [HUW-1:0] hu_c, dq, vf;
	logic [2:0]     kc;
	logic [8:0]     mm;
	logic [MW-1:0]  mc;
	logic [29:0]    xc, x2c;
	logic [30:0]    ts7, tc7, ts9, tc9, ts11, tc11;
	logic [30:0]    sv, cv;
	logic signed [31:0] s_c, c_c;

	always_comb begin
		hu_c = HUW'($signed(angle[31:FRAC_BITS])) + HUW'(OFS);
		dq   = HUW'(prod_s1 >> SH360);
		vf   = hu_s1 - HUW'(dq * HUW'(360));
		kc   = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (v_s2 >= 9'(45 * i)) kc = kc + 3'd1;
		end
		mm = v_s2 - 9'(kc * 9'd45);
		mc = {mm[5:0], low_s2};
		// odd octants measure from the far edge
		if (kc[0]) mc = OCT - mc;
		xc   = pm_s4[FRAC_BITS+2 +: 30];
		x2c  = px2_s5[59:30];
		ts7  = Q30_ONE - 31'(p42_s6 >> 37);
		tc7  = Q30_ONE - 31'(p56_s6 >> 37);
		ts9  = Q30_ONE - 31'(p20_s8 >> 36);
		tc9  = Q30_ONE - 31'(p30_s8 >> 36);
		ts11 = Q30_ONE - 31'(p6_s10 >> 34);
		tc11 = Q30_ONE - 31'(p12_s10 >> 35);
		sv   = ms_s11[60:30];
		cv   = Q30_ONE - {1'b0, mc_s11[60:31]};
		if (k_s11 inside {3'd1, 3'd2, 3'd5, 3'd6}) begin
			s_c = $signed(32'(cv));
			c_c = $signed(32'(sv));
		end else begin
			s_c = $signed(32'(sv));
			c_c = $signed(32'(cv));
		end
		if (k_s11[2]) s_c = -s_c;
		if (k_s11 inside {3'd2, 3'd3, 3'd4, 3'd5}) c_c = -c_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= hu_c * R360;
			hu_s1   <= hu_c;
			low_s1  <= angle[FRAC_BITS-1:0];

			v_s2   <= vf[8:0];
			low_s2 <= low_s1;

			k_s3 <= kc;
			m_s3 <= mc;

			pm_s4 <= m_s3 * PI_OVER_180;
			k_s4  <= k_s3;

			x_s5   <= xc;
			px2_s5 <= xc * xc;
			k_s5   <= k_s4;

			x_s6   <= x_s5;
			x2_s6  <= x2c;
			p42_s6 <= x2c * M42;
			p56_s6 <= x2c * M56;
			k_s6   <= k_s5;

			ms_s7 <= x2_s6 * ts7;
			mc_s7 <= x2_s6 * tc7;
			x_s7  <= x_s6;
			x2_s7 <= x2_s6;
			k_s7  <= k_s6;

			p20_s8 <= ms_s7[60:30] * M20;
			p30_s8 <= mc_s7[60:30] * M30;
			x_s8   <= x_s7;
			x2_s8  <= x2_s7;
			k_s8   <= k_s7;

			ms_s9 <= x2_s8 * ts9;
			mc_s9 <= x2_s8 * tc9;
			x_s9  <= x_s8;
			x2_s9 <= x2_s8;
			k_s9  <= k_s8;

			p6_s10  <= ms_s9[60:30] * M6;
			p12_s10 <= mc_s9[60:30] * M12;
			x_s10   <= x_s9;
			x2_s10  <= x2_s9;
			k_s10   <= k_s9;

			ms_s11 <= x_s10 * ts11;
			mc_s11 <= x2_s10 * tc11;
			k_s11  <= k_s10;

			s_s12 <= s_c;
			c_s12 <= c_c;
		end
	end

	assign sin_val = s_s12;
	assign cos_val = c_s12;

endmodule

FILE: design/trs_rot.sv
// Pipelined Z*Y*X rotation matrix from three sine/cosine pairs.
`timescale 1ns / 1ps
module trs_rot import trs_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] sx,
	input  logic signed [31:0] cx,
	input  logic signed [31:0] sy,
	input  logic signed [31:0] cy,
	input  logic signed [31:0] sz,
	input  logic signed [31:0] cz,
	output rent_t              r [3][3]
);

	logic signed [63:0] czsy_s1, szsy_s1, p00_s1, szcx_s1, szsx_s1, p10_s1;
	logic signed [63:0] czcx_s1, czsx_s1, p21_s1, p22_s1;
	logic signed [31:0] sx_s1, cx_s1, sy_s1;
	logic signed [31:0] czsy_s2, szsy_s2, t00_s2, szcx_s2, szsx_s2, t10_s2;
	logic signed [31:0] czcx_s2, czsx_s2, t21_s2, t22_s2, sx_s2, cx_s2, sy_s2;
	logic signed [63:0] qa_s3, qb_s3, qc_s3, qd_s3;
	logic signed [31:0] t00_s3, szcx_s3, szsx_s3, t10_s3, czcx_s3, czsx_s3;
	logic signed [31:0] t21_s3, t22_s3, sy_s3;
	logic signed [31:0] qa_s4, qb_s4, qc_s4, qd_s4;
	logic signed [31:0] t00_s4, szcx_s4, szsx_s4, t10_s4, czcx_s4, czsx_s4;
	logic signed [31:0] t21_s4, t22_s4, sy_s4;
	rent_t r_s5 [3][3];

	function automatic logic signed [31:0] rq(input logic signed [63:0] p);
		return 32'(rnd_q30(65'(p)));
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			czsy_s1 <= cz * sy;
			szsy_s1 <= sz * sy;
			p00_s1  <= cz * cy;
			szcx_s1 <= sz * cx;
			szsx_s1 <= sz * sx;
			p10_s1  <= sz * cy;
			czcx_s1 <= cz * cx;
			czsx_s1 <= cz * sx;
			p21_s1  <= cy * sx;
			p22_s1  <= cy * cx;
			sx_s1   <= sx;
			cx_s1   <= cx;
			sy_s1   <= sy;

			czsy_s2 <= rq(czsy_s1);
			szsy_s2 <= rq(szsy_s1);
			t00_s2  <= rq(p00_s1);
			szcx_s2 <= rq(szcx_s1);
			szsx_s2 <= rq(szsx_s1);
			t10_s2  <= rq(p10_s1);
			czcx_s2 <= rq(czcx_s1);
			czsx_s2 <= rq(czsx_s1);
			t21_s2  <= rq(p21_s1);
			t22_s2  <= rq(p22_s1);
			sx_s2   <= sx_s1;
			cx_s2   <= cx_s1;
			sy_s2   <= sy_s1;

			qa_s3   <= czsy_s2 * sx_s2;
			qb_s3   <= czsy_s2 * cx_s2;
			qc_s3   <= szsy_s2 * sx_s2;
			qd_s3   <= szsy_s2 * cx_s2;
			t00_s3  <= t00_s2;
			szcx_s3 <= szcx_s2;
			szsx_s3 <= szsx_s2;
			t10_s3  <= t10_s2;
			czcx_s3 <= czcx_s2;
			czsx_s3 <= czsx_s2;
			t21_s3  <= t21_s2;
			t22_s3  <= t22_s2;
			sy_s3   <= sy_s2;

			qa_s4   <= rq(qa_s3);
			qb_s4   <= rq(qb_s3);
			qc_s4   <= rq(qc_s3);
			qd_s4   <= rq(qd_s3);
			t00_s4  <= t00_s3;
			szcx_s4 <= szcx_s3;
			szsx_s4 <= szsx_s3;
			t10_s4  <= t10_s3;
			czcx_s4 <= czcx_s3;
			czsx_s4 <= czsx_s3;
			t21_s4  <= t21_s3;
			t22_s4  <= t22_s3;
			sy_s4   <= sy_s3;

			r_s5[0][0] <= 33'(t00_s4);
			r_s5[0][1] <= 33'(qa_s4) - 33'(szcx_s4);
			r_s5[0][2] <= 33'(qb_s4) + 33'(szsx_s4);
			r_s5[1][0] <= 33'(t10_s4);
			r_s5[1][1] <= 33'(qc_s4) + 33'(czcx_s4);
			r_s5[1][2] <= 33'(qd_s4) - 33'(czsx_s4);
			r_s5[2][0] <= -33'(sy_s4);
			r_s5[2][1] <= 33'(t21_s4);
			r_s5[2][2] <= 33'(t22_s4);
		end
	end

	assign r = r_s5;

endmodule

FILE: design/trs_scale.sv
// Pipelined column scaling with rounding and saturation to 32 bits.
`timescale 1ns / 1ps
module trs_scale import trs_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  rent_t              r [3][3],
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] scale_z,
	output logic [31:0]        ent [3][3]
);

	logic signed [31:0] scl [3];
	logic signed [64:0] p_s1 [3][3];
	logic signed [35:0] rd_s2 [3][3];
	logic [31:0]        ent_s3 [3][3];

	assign scl[0] = scale_x;
	assign scl[1] = scale_y;
	assign scl[2] = scale_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s1[i][j]   <= r[i][j] * scl[j];
					rd_s2[i][j]  <= rnd_q30(p_s1[i][j]);
					ent_s3[i][j] <= sat32(rd_s2[i][j]);
				end
			end
		end
	end

	assign ent = ent_s3;

endmodule

FILE: design/trs_euler_transform_matrix.sv
// Top level: Euler ZYX translate-rotate-scale matrix, three rows per item.
// Each item passes the pipeline into a row buffer, which sends rows 0, 1 and 2 in order.
// Items share the single row output port (3 rows/item); a row is held while row_stall is high.
// The 20-stage pipeline runs under one enable; it holds only when its last stage is
// full and the row buffer cannot take it.
// Reset clears the stage valid bits, the row buffer valid and the row counter.
`timescale 1ns / 1ps
module trs_euler_transform_matrix import trs_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        xfm_valid,
	output logic        xfm_stall,
	input  logic [31:0] translation_x,
	input  logic [31:0] translation_y,
	input  logic [31:0] translation_z,
	input  logic [31:0] angle_x_deg,
	input  logic [31:0] angle_y_deg,
	input  logic [31:0] angle_z_deg,
	input  logic [31:0] scale_x,
	input  logic [31:0] scale_y,
	input  logic [31:0] scale_z,
	output logic        row_valid,
	input  logic        row_stall,
	output logic [1:0]  row_index,
	output logic [31:0] entry_col0,
	output logic [31:0] entry_col1,
	output logic [31:0] entry_col2,
	output logic [31:0] entry_col3,
	output logic        last_row
);

	localparam int SCL_DLY = SC_STAGES + ROT_STAGES;

	logic [TOT_STAGES-1:0] vld_q;
	vec3_t tr_q [TOT_STAGES];
	vec3_t sc_q [SCL_DLY];

	logic en, can_take, ld;
	logic signed [31:0] sx, cx, sy, cy, sz, cz;
	rent_t       rmat [3][3];
	logic [31:0] ent [3][3];

	logic [31:0] rows_q [3][3];
	vec3_t       trow_q;
	logic [1:0]  row_q;
	logic        ser_vld_q;

	// row buffer frees up as its last row leaves
	assign can_take  = !ser_vld_q || (row_q == 2'd2 && !row_stall);
	assign en        = can_take || !vld_q[TOT_STAGES-1];
	assign ld        = en && vld_q[TOT_STAGES-1];
	assign xfm_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT_STAGES-2:0], xfm_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tr_q[0] <= {translation_x, translation_y, translation_z};
			sc_q[0] <= {scale_x, scale_y, scale_z};
			for (int i = 1; i < TOT_STAGES; i++) tr_q[i] <= tr_q[i-1];
			for (int i = 1; i < SCL_DLY; i++) sc_q[i] <= sc_q[i-1];
		end
	end

	trs_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_x (
		.clk(clk), .en(en), .angle(angle_x_deg), .sin_val(sx), .cos_val(cx)
	);
	trs_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_y (
		.clk(clk), .en(en), .angle(angle_y_deg), .sin_val(sy), .cos_val(cy)
	);
	trs_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_z (
		.clk(clk), .en(en), .angle(angle_z_deg), .sin_val(sz), .cos_val(cz)
	);

	trs_rot u_rot (
		.clk(clk), .en(en),
		.sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
		.r(rmat)
	);

	trs_scale u_scale (
		.clk(clk), .en(en), .r(rmat),
		.scale_x($signed(sc_q[SCL_DLY-1].x)),
		.scale_y($signed(sc_q[SCL_DLY-1].y)),
		.scale_z($signed(sc_q[SCL_DLY-1].z)),
		.ent(ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			row_q     <= 2'd0;
		end else if (ser_vld_q && !row_stall) begin
			if (row_q == 2'd2) begin
				ser_vld_q <= ld;
				row_q     <= 2'd0;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end else if (!ser_vld_q && ld) begin
			ser_vld_q <= 1'b1;
			row_q     <= 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rows_q <= ent;
			trow_q <= tr_q[TOT_STAGES-1];
		end
	end

	always_comb begin
		case (row_q)
			2'd0: begin
				entry_col0 = rows_q[0][0];
				entry_col1 = rows_q[0][1];
				entry_col2 = rows_q[0][2];
				entry_col3 = trow_q.x;
			end
			2'd1: begin
				entry_col0 = rows_q[1][0];
				entry_col1 = rows_q[1][1];
				entry_col2 = rows_q[1][2];
				entry_col3 = trow_q.y;
			end
			default: begin
				entry_col0 = rows_q[2][0];
				entry_col1 = rows_q[2][1];
				entry_col2 = rows_q[2][2];
				entry_col3 = trow_q.z;
			end
		endcase
	end

	assign row_valid = ser_vld_q;
	assign row_index = row_q;
	assign last_row  = (row_q == 2'd2);

endmodule

FILE: dv/tb_trs_euler_transform_matrix.sv
// Self-checking testbench for the Euler ZYX translate-rotate-scale matrix block.
`timescale 1ns / 1ps
module tb_trs_euler_transform_matrix;
	import trs_pkg::*;

	localparam int FRAC      = 16;
	localparam int N_RANDOM  = 168;
	localparam int IDLE_LIM  = 20000;
	localparam int LONG_HOLD = 200;

	typedef struct packed {
		logic [31:0] tx, ty, tz;
		logic [31:0] ax, ay, az;
		logic [31:0] sx, sy, sz;
	} xfm_t;

	typedef struct packed {
		logic [1:0]  idx;
		logic [31:0] c0, c1, c2, c3;
		logic        last;
	} row_t;

	// Q30 product, rounded half away from zero
	function automatic longint mul_q30(longint a, longint b);
		bit neg;
		longint unsigned ua, ub, p;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		p = (ua * ub + (64'd1 << 29)) >> 30;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint unsigned uq30(longint unsigned a, longint unsigned b);
		return (a * b) >> 30;
	endfunction

	function automatic logic [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic void angle_trig(input logic [31:0] ang, output longint s,
			output longint c);
		longint full, oct, r, k, m;
		longint unsigned x, x2, t, sv, cv, one;
		one = 64'd1 << 30;
		full = 360 <<< FRAC;
		oct = 45 <<< FRAC;
		r = longint'($signed(ang)) % full;
		if (r < 0) r += full;
		k = r / oct;
		m = r % oct;
		if (k[0]) m = oct - m;
		x = (longint'(m) * 64'd74961321) >> (FRAC + 2);
		x2 = uq30(x, x);
		t = one - x2 / 42;
		t = one - uq30(x2, t) / 20;
		t = one - uq30(x2, t) / 6;
		sv = uq30(x, t);
		t = one - x2 / 56;
		t = one - uq30(x2, t) / 30;
		t = one - uq30(x2, t) / 12;
		cv = one - uq30(x2, t) / 2;
		if (k == 1 || k == 2 || k == 5 || k == 6) begin
			s = cv; c = sv;
		end else begin
			s = sv; c = cv;
		end
		if (k >= 4) s = -s;
		if (k >= 2 && k <= 5) c = -c;
	endfunction

	class matrix_board;
		row_t pending[$];
		int   errors;
		int   rows_seen;

		function void note_item(xfm_t it);
			longint sx, cx, sy, cy, sz, cz, czsy, szsy;
			longint r[3][3];
			longint scl[3];
			logic [31:0] tr[3];
			row_t e;
			angle_trig(it.ax, sx, cx);
			angle_trig(it.ay, sy, cy);
			angle_trig(it.az, sz, cz);
			czsy = mul_q30(cz, sy);
			szsy = mul_q30(sz, sy);
			r[0][0] = mul_q30(cz, cy);
			r[0][1] = mul_q30(czsy, sx) - mul_q30(sz, cx);
			r[0][2] = mul_q30(czsy, cx) + mul_q30(sz, sx);
			r[1][0] = mul_q30(sz, cy);
			r[1][1] = mul_q30(szsy, sx) + mul_q30(cz, cx);
			r[1][2] = mul_q30(szsy, cx) - mul_q30(cz, sx);
			r[2][0] = -sy;
			r[2][1] = mul_q30(cy, sx);
			r[2][2] = mul_q30(cy, cx);
			scl[0] = $signed(it.sx);
			scl[1] = $signed(it.sy);
			scl[2] = $signed(it.sz);
			tr[0] = it.tx; tr[1] = it.ty; tr[2] = it.tz;
			for (int i = 0; i < 3; i++) begin
				e.idx  = i[1:0];
				e.c0   = clip32(mul_q30(r[i][0], scl[0]));
				e.c1   = clip32(mul_q30(r[i][1], scl[1]));
				e.c2   = clip32(mul_q30(r[i][2], scl[2]));
				e.c3   = tr[i];
				e.last = (i == 2);
				pending.push_back(e);
			end
		endfunction

		function void check_row(row_t got);
			row_t e;
			rows_seen++;
			if (pending.size() == 0) begin
				$error("unexpected row, index %0d", got.idx);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.idx != e.idx) begin
				$error("row_index: expected %0d, got %0d", e.idx, got.idx); errors++;
			end
			if (got.c0 != e.c0) begin
				$error("entry_col0: expected %h, got %h", e.c0, got.c0); errors++;
			end
			if (got.c1 != e.c1) begin
				$error("entry_col1: expected %h, got %h", e.c1, got.c1); errors++;
			end
			if (got.c2 != e.c2) begin
				$error("entry_col2: expected %h, got %h", e.c2, got.c2); errors++;
			end
			if (got.c3 != e.c3) begin
				$error("entry_col3: expected %h, got %h", e.c3, got.c3); errors++;
			end
			if (got.last != e.last) begin
				$error("last_row: expected %0d, got %0d", e.last, got.last); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic xfm_valid = 1'b0;
	logic xfm_stall;
	xfm_t xfm = '0;
	logic row_valid;
	logic row_stall = 1'b0;
	logic [1:0] row_index;
	logic [31:0] entry_col0, entry_col1, entry_col2, entry_col3;
	logic last_row;

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_rows = 1'b0;
	int idle_cycles = 0;
	int items_sent = 0;
	matrix_board board = new();

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	trs_euler_transform_matrix #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk), .arst_n(arst_n),
		.xfm_valid(xfm_valid), .xfm_stall(xfm_stall),
		.translation_x(xfm.tx), .translation_y(xfm.ty), .translation_z(xfm.tz),
		.angle_x_deg(xfm.ax), .angle_y_deg(xfm.ay), .angle_z_deg(xfm.az),
		.scale_x(xfm.sx), .scale_y(xfm.sy), .scale_z(xfm.sz),
		.row_valid(row_valid), .row_stall(row_stall), .row_index(row_index),
		.entry_col0(entry_col0), .entry_col1(entry_col1), .entry_col2(entry_col2),
		.entry_col3(entry_col3), .last_row(last_row)
	);

	// receiver: random stall, long hold when asked; check accepted rows
	always @(posedge clk) begin
		if (arst_n && row_valid && !row_stall)
			board.check_row({row_index, entry_col0, entry_col1, entry_col2,
				entry_col3, last_row});
		row_stall <= hold_rows || ($urandom_range(99) < stall_pct);
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((xfm_valid && !xfm_stall) || (row_valid && !row_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIM) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_item(input xfm_t it);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			xfm_valid <= 1'b0;
			@(posedge clk);
		end
		xfm_valid <= 1'b1;
		xfm <= it;
		@(posedge clk);
		while (xfm_stall) @(posedge clk);
		board.note_item(it);
		items_sent++;
	endtask

	function automatic logic [31:0] pick_field();
		case ($urandom_range(5))
			0: return $urandom();
			1: return 32'h8000_0000 | $urandom_range(3);
			2: return 32'h7FFF_FFFC | $urandom_range(3);
			default: return $signed($urandom_range(0, 1440 << 16)) - (720 << 16);
		endcase
	endfunction

	function automatic xfm_t random_item();
		xfm_t it;
		it.tx = $urandom(); it.ty = $urandom(); it.tz = $urandom();
		it.ax = pick_field(); it.ay = pick_field(); it.az = pick_field();
		// scales mostly moderate, some full range to hit saturation
		it.sx = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		it.sy = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		it.sz = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
		return it;
	endfunction

	task automatic drain();
		xfm_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		logic [31:0] one;
		one = 32'h0001_0000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, every octant, extremes, saturation
		send_item({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, one, one, one});
		for (int k = 0; k < 8; k++)
			send_item({32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
				32'((k * 45 + 10) << 16), 32'((k * 45 + 30) << 16),
				32'((k * 45) << 16), one, one, one});
		send_item({32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
		send_item({32'd1, 32'd2, 32'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
		send_item({32'd0, 32'd0, 32'd0, 32'hFE98_0000, 32'h0168_0000, 32'h00B4_0000,
			32'hFFFF_0000, 32'hFFFF_FFFF, 32'd0});
		send_item({32'hFFFF_FFFF, 32'd0, 32'hAAAA_5555, 32'd0, 32'h005A_0000,
			32'hFFA6_0000, 32'h4000_0000, 32'hC000_0000, 32'h5555_AAAA});
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 50 : 0;
			stall_pct = (ph == 3) ? 26 : (ph == 2 ? 50 : 0);
			if (ph == 3) send_idle_pct = 26;
			if (ph == 0) begin
				// long receiver hold while items keep coming
				fork
					begin
						hold_rows = 1'b1;
						repeat (LONG_HOLD) @(posedge clk);
						hold_rows = 1'b0;
					end
					for (int n = 0; n < 40; n++) send_item(random_item());
				join
			end
			for (int n = 0; n < N_RANDOM / 4; n++) send_item(random_item());
		end
		stall_pct = 0;
		drain();

		$display("Sent %0d transforms, checked %0d rows across four idle/stall mixes.",
			items_sent, board.rows_seen);
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
